@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every cycle outside reset.
`define CCU_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ccu assertion failed");

// Property checked every cycle, reset included.
`define CCU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ccu assertion failed");

`endif

@@ rtl/ccu_pkg.sv @@
// Package with constants and types of the copying heap collector.
`timescale 1ns / 1ps
package ccu_pkg;

    localparam int HEAP_WORDS_DEF  = 4096;
    localparam int SPACE_WORDS_DEF = 2048;

    localparam logic [3:0] CMD_ALLOC_REC = 4'd0;
    localparam logic [3:0] CMD_ALLOC_ARR = 4'd1;
    localparam logic [3:0] CMD_ROOM      = 4'd2;
    localparam logic [3:0] CMD_WRITE     = 4'd3;
    localparam logic [3:0] CMD_READ      = 4'd4;
    localparam logic [3:0] CMD_FWD_QUERY = 4'd5;
    localparam logic [3:0] CMD_BEGIN     = 4'd6;
    localparam logic [3:0] CMD_COPY_ROOT = 4'd7;
    localparam logic [3:0] CMD_FINISH    = 4'd8;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_OOM      = 2'd2;
    localparam logic [1:0] ST_BAD_PTR  = 2'd3;

    localparam logic [31:0] FWD_HDR   = 32'h2;
    localparam logic [31:0] HDR_LIMIT = 32'h0040_0000;

    localparam logic REG_HEAP_BASE = 1'b0;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_stat;

    function automatic logic is_header(input logic [31:0] v);
        return (v[1:0] == 2'b10) && (v < HDR_LIMIT);
    endfunction

endpackage

@@ rtl/ccu_heap_mem.sv @@
// Heap word memory: one write port, one registered read port.
`timescale 1ns / 1ps
module ccu_heap_mem
    import ccu_pkg::*;
#(
    parameter int HEAP_WORDS = HEAP_WORDS_DEF,
    localparam int AW = $clog2(HEAP_WORDS)
) (
    input  logic          i_clk,
    input  t_mem_ctl      i_ctl,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_data,
    output logic [31:0]   o_rd_data
);

    logic [31:0] r_mem [HEAP_WORDS];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/ccu_engine.sv @@
// Sequencer for allocation, access, forwarding and collection.
`timescale 1ns / 1ps
module ccu_engine
    import ccu_pkg::*;
#(
    parameter int HEAP_WORDS  = HEAP_WORDS_DEF,
    parameter int SPACE_WORDS = SPACE_WORDS_DEF,
    localparam int AW = $clog2(HEAP_WORDS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [3:0]    i_cmd,
    input  logic [10:0]   i_count,
    input  logic [11:0]   i_word_index,
    input  logic [31:0]   i_pointer,
    input  logic [31:0]   i_data,
    input  logic [31:0]   i_base,
    output t_eng_stat     o_stat,
    output logic [1:0]    o_status,
    output logic [31:0]   o_value,
    output logic [11:0]   o_free_words,
    output t_mem_ctl      o_mem_ctl,
    output logic [AW-1:0] o_rd_addr,
    output logic [AW-1:0] o_wr_addr,
    output logic [31:0]   o_wr_data,
    input  logic [31:0]   i_rd_data
);

    localparam int FW = $clog2(SPACE_WORDS + 1);
    localparam logic [AW:0]   SPACE_A    = (AW+1)'(SPACE_WORDS);
    localparam logic [32:0]   HEAP_BYTES = 33'(4 * HEAP_WORDS);
    localparam logic [31:0]   SPACE_32   = 32'(SPACE_WORDS);
    localparam logic [AW-1:0] LAST_WORD  = AW'(HEAP_WORDS - 1);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_EXEC     = 5'd1;
    localparam logic [4:0] S_RDW      = 5'd2;
    localparam logic [4:0] S_FQ_CHK   = 5'd3;
    localparam logic [4:0] S_FQ_FWD   = 5'd4;
    localparam logic [4:0] S_CW_START = 5'd5;
    localparam logic [4:0] S_CW_SRCH  = 5'd6;
    localparam logic [4:0] S_CW_FWD   = 5'd7;
    localparam logic [4:0] S_CW_CHK   = 5'd8;
    localparam logic [4:0] S_CW_CWR   = 5'd9;
    localparam logic [4:0] S_CW_FIN   = 5'd10;
    localparam logic [4:0] S_CW_FIN2  = 5'd11;
    localparam logic [4:0] S_CW_RET   = 5'd12;
    localparam logic [4:0] S_FIN_TOP  = 5'd13;
    localparam logic [4:0] S_FIN_HDR  = 5'd14;
    localparam logic [4:0] S_SC_J     = 5'd15;
    localparam logic [4:0] S_SC_RD    = 5'd16;
    localparam logic [4:0] S_FIN_ADV  = 5'd17;
    localparam logic [4:0] S_DONE     = 5'd18;
    localparam logic [4:0] S_CLEAR    = 5'd19;

    logic [4:0]    r_state, n_state;
    logic [3:0]    r_cmd, n_cmd;
    logic [10:0]   r_count, n_count;
    logic [11:0]   r_widx, n_widx;
    logic [31:0]   r_ptr, n_ptr;
    logic [31:0]   r_data, n_data;
    logic [FW-1:0] r_free, n_free;
    logic          r_half, n_half;
    logic [FW:0]   r_scan, n_scan;
    logic          r_coll, n_coll;
    logic [1:0]    r_st, n_st;
    logic [31:0]   r_val, n_val;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_q, n_q;
    logic [31:0]   r_h, n_h;
    logic [28:0]   r_size, n_size;
    logic [28:0]   r_ssize, n_ssize;
    logic [FW-1:0] r_k, n_k;
    logic [FW-1:0] r_j, n_j;
    logic [AW-1:0] r_dst, n_dst;
    logic [AW-1:0] r_a, n_a;
    logic [31:0]   r_cwp, n_cwp;
    logic [31:0]   r_res, n_res;
    logic          r_scan_call, n_scan_call;
    logic [AW-1:0] r_clr, n_clr;

    logic [AW-1:0] to_w, from_w;
    logic [AW:0]   from_end;
    logic [31:0]   p_sel, loc_off, rb_src, rb_out, cp_addr;
    logic          loc_ok;
    logic [AW-1:0] loc_w;
    logic [11:0]   need;
    logic [28:0]   sz_h, sz_scan;
    logic [31:0]   widx32;

    assign to_w     = r_half ? AW'(SPACE_WORDS) : '0;
    assign from_w   = r_half ? '0 : AW'(SPACE_WORDS);
    assign from_end = {1'b0, from_w} + SPACE_A;

    assign p_sel   = (r_state == S_EXEC || r_state == S_FQ_FWD) ? r_ptr : r_cwp;
    assign loc_off = p_sel - i_base;
    assign loc_ok  = (p_sel >= i_base) && ({1'b0, loc_off} < HEAP_BYTES);
    assign loc_w   = loc_off[AW+1:2];

    // rebase: new header address plus the pointer's offset from the old header
    assign cp_addr = i_base + {{(30-AW){1'b0}}, r_dst, 2'b00};
    always_comb begin
        unique case (r_state)
            S_CW_FIN2: rb_src = cp_addr;
            default:   rb_src = (r_q == LAST_WORD) ? '0 : i_rd_data;
        endcase
    end
    assign rb_out = rb_src + (p_sel - i_base - {{(30-AW){1'b0}}, r_q, 2'b00});

    assign need    = ((r_count == '0) ? 12'd1 : {1'b0, r_count}) + 12'd1;
    assign sz_h    = r_h[31:3];
    assign sz_scan = (i_rd_data[31:3] == '0) ? 29'd1 : i_rd_data[31:3];
    assign widx32  = {20'b0, r_widx};

    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_count = r_count; n_widx = r_widx;
        n_ptr = r_ptr; n_data = r_data; n_free = r_free; n_half = r_half;
        n_scan = r_scan; n_coll = r_coll; n_st = r_st; n_val = r_val;
        n_i = r_i; n_q = r_q; n_h = r_h; n_size = r_size; n_ssize = r_ssize;
        n_k = r_k; n_j = r_j; n_dst = r_dst; n_a = r_a; n_cwp = r_cwp;
        n_res = r_res; n_scan_call = r_scan_call; n_clr = r_clr;
        o_mem_ctl = '0;
        o_rd_addr = '0;
        o_wr_addr = '0;
        o_wr_data = '0;
        o_stat    = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_mem_ctl.wr = 1'b1;
                o_wr_addr = r_clr;
                o_wr_data = '0;
                n_clr = r_clr + AW'(1);
                if (r_clr == LAST_WORD) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_stat.idle = 1'b1;
                if (i_start) begin
                    n_cmd = i_cmd; n_count = i_count; n_widx = i_word_index;
                    n_ptr = i_pointer; n_data = i_data;
                    n_st = ST_OK; n_val = '0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_cmd)
                    CMD_ALLOC_REC, CMD_ALLOC_ARR, CMD_ROOM: begin
                        if (32'(need) > SPACE_32) begin
                            n_st = ST_OOM;
                        end else if (32'(need) > SPACE_32 - 32'(r_free)) begin
                            n_st = ST_FULL;
                        end else if (r_cmd != CMD_ROOM) begin
                            o_mem_ctl.wr = 1'b1;
                            o_wr_addr = to_w + AW'(r_free);
                            o_wr_data = {17'b0, need, r_cmd == CMD_ALLOC_ARR, 2'b10};
                            n_val = i_base + ((32'(to_w) + 32'(r_free) + 32'd1) << 2);
                            n_free = r_free + FW'(need);
                        end
                    end
                    CMD_WRITE: begin
                        if (widx32 < 32'(HEAP_WORDS)) begin
                            o_mem_ctl.wr = 1'b1;
                            o_wr_addr = widx32[AW-1:0];
                            o_wr_data = r_data;
                        end
                    end
                    CMD_READ: begin
                        if (widx32 < 32'(HEAP_WORDS)) begin
                            o_mem_ctl.rd = 1'b1;
                            o_rd_addr = widx32[AW-1:0];
                            n_state = S_RDW;
                        end
                    end
                    CMD_FWD_QUERY: begin
                        n_val = r_ptr;
                        if (!r_ptr[0] && loc_ok && loc_w != '0) begin
                            n_i = loc_w - AW'(1);
                            o_mem_ctl.rd = 1'b1;
                            o_rd_addr = loc_w - AW'(1);
                            n_state = S_FQ_CHK;
                        end
                    end
                    CMD_BEGIN: begin
                        if (!r_coll) begin
                            n_half = ~r_half; n_free = '0; n_scan = '0; n_coll = 1'b1;
                        end
                    end
                    CMD_COPY_ROOT: begin
                        if (r_coll) begin
                            n_cwp = r_ptr; n_scan_call = 1'b0; n_state = S_CW_START;
                        end else begin
                            n_val = r_ptr;
                        end
                    end
                    CMD_FINISH: begin
                        if (r_coll) n_state = S_FIN_TOP;
                    end
                    default: ;
                endcase
            end
            S_RDW: begin
                n_val = i_rd_data;
                n_state = S_DONE;
            end
            S_FQ_CHK: begin
                if (is_header(i_rd_data)) begin
                    if (i_rd_data == FWD_HDR) begin
                        n_q = r_i;
                        o_mem_ctl.rd = 1'b1;
                        o_rd_addr = r_i + AW'(1);
                        n_state = S_FQ_FWD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (r_i == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_i = r_i - AW'(1);
                    o_mem_ctl.rd = 1'b1;
                    o_rd_addr = r_i - AW'(1);
                end
            end
            S_FQ_FWD: begin
                n_val = rb_out;
                n_state = S_DONE;
            end
            S_CW_START: begin
                n_res = r_cwp;
                n_state = S_CW_RET;
                if (!r_cwp[0] && loc_ok) begin
                    if ({1'b0, loc_w} < {1'b0, from_w} || {1'b0, loc_w} >= from_end
                        || loc_w == from_w) begin
                        n_st = (r_st == ST_OK) ? ST_BAD_PTR : r_st;
                    end else begin
                        n_i = loc_w - AW'(1);
                        o_mem_ctl.rd = 1'b1;
                        o_rd_addr = loc_w - AW'(1);
                        n_state = S_CW_SRCH;
                    end
                end
            end
            S_CW_SRCH: begin
                if (is_header(i_rd_data)) begin
                    n_q = r_i;
                    n_h = i_rd_data;
                    if (i_rd_data == FWD_HDR) begin
                        o_mem_ctl.rd = 1'b1;
                        o_rd_addr = r_i + AW'(1);
                        n_state = S_CW_FWD;
                    end else begin
                        n_state = S_CW_CHK;
                    end
                end else if (r_i == from_w) begin
                    n_st = (r_st == ST_OK) ? ST_BAD_PTR : r_st;
                    n_state = S_CW_RET;
                end else begin
                    n_i = r_i - AW'(1);
                    o_mem_ctl.rd = 1'b1;
                    o_rd_addr = r_i - AW'(1);
                end
            end
            S_CW_FWD: begin
                n_res = rb_out;
                n_state = S_CW_RET;
            end
            S_CW_CHK: begin
                if (sz_h < 29'd2 || 32'(sz_h) > 32'(from_end - {1'b0, r_q})) begin
                    n_st = (r_st == ST_OK) ? ST_BAD_PTR : r_st;
                    n_state = S_CW_RET;
                end else if (32'(sz_h) > SPACE_32 - 32'(r_free)) begin
                    n_st = (r_st == ST_OK) ? ST_OOM : r_st;
                    n_state = S_CW_RET;
                end else begin
                    n_size = sz_h;
                    n_k = '0;
                    n_dst = to_w + AW'(r_free);
                    o_mem_ctl.rd = 1'b1;
                    o_rd_addr = r_q;
                    n_state = S_CW_CWR;
                end
            end
            S_CW_CWR: begin
                o_mem_ctl.wr = 1'b1;
                o_wr_addr = r_dst + AW'(r_k);
                o_wr_data = i_rd_data;
                if (32'(r_k) + 32'd1 == 32'(r_size)) begin
                    n_state = S_CW_FIN;
                end else begin
                    o_mem_ctl.rd = 1'b1;
                    o_rd_addr = r_q + AW'(r_k) + AW'(1);
                    n_k = r_k + FW'(1);
                end
            end
            S_CW_FIN: begin
                o_mem_ctl.wr = 1'b1;
                o_wr_addr = r_q + AW'(1);
                o_wr_data = cp_addr;
                n_state = S_CW_FIN2;
            end
            S_CW_FIN2: begin
                o_mem_ctl.wr = 1'b1;
                o_wr_addr = r_q;
                o_wr_data = FWD_HDR;
                n_free = r_free + FW'(r_size);
                n_res = rb_out;
                n_state = S_CW_RET;
            end
            S_CW_RET: begin
                if (r_scan_call) begin
                    o_mem_ctl.wr = 1'b1;
                    o_wr_addr = r_a;
                    o_wr_data = r_res;
                    n_j = r_j + FW'(1);
                    n_state = S_SC_J;
                end else begin
                    n_val = r_res;
                    n_state = S_DONE;
                end
            end
            S_FIN_TOP: begin
                if (r_scan < {1'b0, r_free}) begin
                    o_mem_ctl.rd = 1'b1;
                    o_rd_addr = to_w + AW'(r_scan);
                    n_state = S_FIN_HDR;
                end else begin
                    n_scan = {1'b0, r_free};
                    n_coll = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_FIN_HDR: begin
                n_ssize = sz_scan;
                if (!i_rd_data[2]) begin
                    n_j = FW'(1);
                    n_state = S_SC_J;
                end else begin
                    n_state = S_FIN_ADV;
                end
            end
            S_SC_J: begin
                if (32'(r_j) < {3'b0, r_ssize} && 32'(r_scan) + 32'(r_j) < SPACE_32) begin
                    n_a = to_w + AW'(r_scan) + AW'(r_j);
                    o_mem_ctl.rd = 1'b1;
                    o_rd_addr = to_w + AW'(r_scan) + AW'(r_j);
                    n_state = S_SC_RD;
                end else begin
                    n_state = S_FIN_ADV;
                end
            end
            S_SC_RD: begin
                n_cwp = i_rd_data;
                n_scan_call = 1'b1;
                n_state = S_CW_START;
            end
            S_FIN_ADV: begin
                n_scan = r_scan + (({3'b0, r_ssize} < SPACE_32) ?
                    (FW+1)'(r_ssize) : (FW+1)'(SPACE_WORDS));
                n_state = S_FIN_TOP;
            end
            S_DONE: begin
                o_stat.done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_free <= '0;
            r_half <= 1'b0;
            r_scan <= '0;
            r_coll <= 1'b0;
            r_clr <= '0;
        end else begin
            r_state <= n_state;
            r_free <= n_free;
            r_half <= n_half;
            r_scan <= n_scan;
            r_coll <= n_coll;
            r_clr <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_count <= n_count; r_widx <= n_widx;
        r_ptr <= n_ptr; r_data <= n_data; r_st <= n_st; r_val <= n_val;
        r_i <= n_i; r_q <= n_q; r_h <= n_h; r_size <= n_size; r_ssize <= n_ssize;
        r_k <= n_k; r_j <= n_j; r_dst <= n_dst; r_a <= n_a; r_cwp <= n_cwp;
        r_res <= n_res; r_scan_call <= n_scan_call;
    end

    assign o_status     = r_st;
    assign o_value      = r_val;
    assign o_free_words = 12'(SPACE_32 - 32'(r_free));

endmodule

@@ rtl/copying_heap_collector_unit.sv @@
// Top level of the copying heap collector: ports, config register, output stage.
`timescale 1ns / 1ps
// Semispace heap engine with a Cheney copying collector.
// Input stream: one command item per handshake (cmd in tuser, operands in tdata).
// Output stream: one result item per command (status in tuser, value and free
// word count in tdata), held in an output register until taken.
// APB port: heap_base register at byte address 0.
// A forward query searches down from the pointer for a header and reads the
// forwarding word when the object was forwarded. Copy root searches for the
// header, copies the object word by word, then writes the forwarding word and
// header (only the search and the forwarding word when already forwarded,
// nothing when the pointer passes unchanged); finish walks the to-space and
// runs a copy for every pointer field, so it runs for data-dependent time.
// One item is worked on at a time; the next can be taken in the cycle the result
// appears, once the output register is free or being emptied in the same cycle.
// Reset clears the allocation state, the base register and the output stage, then
// the engine writes zero to every heap word, one a cycle, and input is held off
// until every word is cleared. A stalled receiver holds the result and blocks the
// next item.
module copying_heap_collector_unit
    import ccu_pkg::*;
#(
    parameter int HEAP_WORDS  = HEAP_WORDS_DEF,
    parameter int SPACE_WORDS = SPACE_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // count, word_index, pointer, data
    input  logic [3:0]  s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // value, free_words
    output logic [1:0]  m_axis_tuser,  // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(HEAP_WORDS);

    logic [31:0]   r_base;
    logic          r_m_valid;
    logic [47:0]   r_m_data;
    logic [1:0]    r_m_user;
    t_eng_stat     eng_stat;
    t_mem_ctl      mem_ctl;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   wr_data, rd_data;
    logic [1:0]    e_status;
    logic [31:0]   e_value;
    logic [11:0]   e_free;
    logic          start;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEAP_BASE) ? r_base : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_HEAP_BASE) begin
            r_base <= {pwdata[31:2], 2'b00};
        end
    end

    assign s_axis_tready = eng_stat.idle && (!r_m_valid || m_axis_tready);
    assign start = s_axis_tvalid && s_axis_tready;

    ccu_heap_mem #(.HEAP_WORDS(HEAP_WORDS)) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    ccu_engine #(.HEAP_WORDS(HEAP_WORDS), .SPACE_WORDS(SPACE_WORDS)) u_eng (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cmd        (s_axis_tuser),
        .i_count      (s_axis_tdata[10:0]),
        .i_word_index (s_axis_tdata[22:11]),
        .i_pointer    (s_axis_tdata[54:23]),
        .i_data       (s_axis_tdata[86:55]),
        .i_base       (r_base),
        .o_stat       (eng_stat),
        .o_status     (e_status),
        .o_value      (e_value),
        .o_free_words (e_free),
        .o_mem_ctl    (mem_ctl),
        .o_rd_addr    (rd_addr),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .i_rd_data    (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (eng_stat.done) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_stat.done) begin
            r_m_data <= {4'b0, e_free, e_value};
            r_m_user <= e_status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

@@ rtl/ccu_checker.sv @@
// Port-level checks of the copying heap collector, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ccu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    `CCU_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `CCU_ASSERT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    `CCU_ASSERT(a_one_result, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    `CCU_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind copying_heap_collector_unit ccu_checker u_ccu_checker (.*);
